// ===== rtl/hrls_pkg.sv =====
`timescale 1ns / 1ps

package hrls_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int TOTAL_W = 32;

	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [2:0] METHOD_UNKNOWN = 3'd4;
	localparam logic [2:0] URI_UNKNOWN = 3'd5;
	localparam int N_METHOD = 5;
	localparam int N_URI = 6;

	// strings are right-justified: the last character sits in bits [7:0]
	localparam logic [63:0] METHOD_STR [4] = '{"GET", "POST", "PUT", "DELETE"};
	localparam logic [3:0] METHOD_LEN [4] = '{4'd3, 4'd4, 4'd3, 4'd6};
	localparam logic [63:0] URI_STR [5] = '{"/", "/order", "/product", "/basket", "/help"};
	localparam logic [3:0] URI_LEN [5] = '{4'd1, 4'd6, 4'd8, 4'd7, 4'd5};

	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_end;
	} chr_t;

	typedef struct packed {
		logic [2:0]  method_class;
		logic [2:0]  uri_class;
		logic [31:0] method_total;
		logic [31:0] uri_total;
	} stat_t;

	typedef struct packed {
		logic [2:0] method_class;
		logic [2:0] uri_class;
	} cls_t;

	// character at position p of a right-justified string of length len (p < len)
	function automatic logic [7:0] str_byte(logic [63:0] s, logic [3:0] len, logic [2:0] p);
		logic [2:0] k;
		k = 3'(len - 4'd1 - {1'b0, p});
		return s[{k, 3'b000} +: 8];
	endfunction

	function automatic logic [2:0] method_now(logic [3:0] hits, logic [3:0] pos);
		logic [2:0] r;
		r = METHOD_UNKNOWN;
		for (int i = 3; i >= 0; i--) begin
			if (hits[i] && METHOD_LEN[i] == pos)
				r = 3'(i);
		end
		return r;
	endfunction

	function automatic logic [4:0] uri_full(logic [4:0] hits, logic [3:0] pos);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 5; i++)
			r[i] = hits[i] && (URI_LEN[i] == pos);
		return r;
	endfunction

	function automatic logic [2:0] uri_pick(logic [4:0] bits);
		logic [2:0] r;
		r = URI_UNKNOWN;
		for (int i = 4; i >= 0; i--) begin
			if (bits[i])
				r = 3'(i);
		end
		return r;
	endfunction

endpackage

// ===== rtl/hrls_bank.sv =====
`timescale 1ns / 1ps

module hrls_bank import hrls_pkg::*; #(
	parameter int DEPTH = N_METHOD,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	output logic [COUNT_BITS-1:0]    nxt_count
);

	localparam int AW = $clog2(DEPTH);

	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]      vld_q;

	logic [COUNT_BITS-1:0] rd_s2;
	logic [AW-1:0]         addr_s2;
	logic                  vld_s2;
	logic                  fwd_s2;
	logic [COUNT_BITS-1:0] fwd_data_s2;
	logic [COUNT_BITS-1:0] cur;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_s2] <= nxt_count;
		if (rd_en)
			rd_s2 <= mem[rd_addr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr_s2] <= 1'b1;
		end
	end

	// forward the value written in the same cycle as the read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s2     <= rd_addr;
			vld_s2      <= vld_q[rd_addr];
			fwd_s2      <= wr_en && (addr_s2 == rd_addr);
			fwd_data_s2 <= nxt_count;
		end
	end

	always_comb begin
		if (fwd_s2)
			cur = fwd_data_s2;
		else if (vld_s2)
			cur = rd_s2;
		else
			cur = '0;
		nxt_count = (&cur) ? cur : cur + COUNT_BITS'(1);
	end

endmodule

// ===== rtl/hrls_parse.sv =====
`timescale 1ns / 1ps

module hrls_parse import hrls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic chr_valid,
	output logic chr_ready,
	input  chr_t chr,
	input  logic s2_free,
	output logic ev_valid,
	output cls_t ev
);

	logic       skip_q, skip_n;
	logic [1:0] tok_q, tok_n;
	logic [3:0] pos_q, pos_n;
	logic [3:0] mh_q, mh_n;
	logic [4:0] uh_q, uh_n;
	logic [2:0] held_q, held_n;
	logic       is_sp;
	logic       chr_go;
	cls_t       cls;

	assign is_sp = (chr.char_byte == SPACE_BYTE);
	assign chr_ready = !ev_valid || s2_free;
	assign chr_go = chr_valid && chr_ready;

	always_comb begin
		skip_n = skip_q;
		tok_n  = tok_q;
		pos_n  = pos_q;
		mh_n   = mh_q;
		uh_n   = uh_q;
		held_n = held_q;
		if (!(skip_q && is_sp)) begin
			skip_n = 1'b0;
			if (is_sp) begin
				// close the current token
				if (tok_q == 2'd0)
					held_n = method_now(mh_q, pos_q);
				else if (tok_q == 2'd1)
					uh_n = uri_full(uh_q, pos_q);
				if (tok_q != 2'd3)
					tok_n = tok_q + 2'd1;
				pos_n = '0;
				mh_n  = '1;
			end else begin
				if (tok_q == 2'd0) begin
					for (int i = 0; i < 4; i++) begin
						if (pos_q >= METHOD_LEN[i] ||
						    str_byte(METHOD_STR[i], METHOD_LEN[i], pos_q[2:0]) != chr.char_byte)
							mh_n[i] = 1'b0;
					end
				end else if (tok_q == 2'd1) begin
					for (int i = 0; i < 5; i++) begin
						if (pos_q >= URI_LEN[i] ||
						    str_byte(URI_STR[i], URI_LEN[i], pos_q[2:0]) != chr.char_byte)
							uh_n[i] = 1'b0;
					end
				end
				if (pos_q != 4'd15)
					pos_n = pos_q + 4'd1;
			end
		end
	end

	// classify on the state after this byte; a missing token is unknown
	always_comb begin
		case (tok_n)
			2'd0: begin
				cls.method_class = method_now(mh_n, pos_n);
				cls.uri_class    = URI_UNKNOWN;
			end
			2'd1: begin
				cls.method_class = held_n;
				cls.uri_class    = uri_pick(uri_full(uh_n, pos_n));
			end
			default: begin
				cls.method_class = held_n;
				cls.uri_class    = uri_pick(uh_n);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b1;
			tok_q  <= '0;
			pos_q  <= '0;
			mh_q   <= '1;
			uh_q   <= '1;
			held_q <= METHOD_UNKNOWN;
		end else if (chr_go) begin
			if (chr.line_end) begin
				skip_q <= 1'b1;
				tok_q  <= '0;
				pos_q  <= '0;
				mh_q   <= '1;
				uh_q   <= '1;
				held_q <= METHOD_UNKNOWN;
			end else begin
				skip_q <= skip_n;
				tok_q  <= tok_n;
				pos_q  <= pos_n;
				mh_q   <= mh_n;
				uh_q   <= uh_n;
				held_q <= held_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid <= 1'b0;
		end else if (chr_go && chr.line_end) begin
			ev_valid <= 1'b1;
		end else if (s2_free) begin
			ev_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_go && chr.line_end)
			ev <= cls;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		tok_q == 2'd0 |-> held_q == METHOD_UNKNOWN)
		else $error("held method set before the first token ended");

	assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (tok_q == 2'd0 && pos_q == 4'd0 && mh_q == 4'hF && uh_q == 5'h1F))
		else $error("token state moved while skipping leading spaces");

endmodule

// ===== rtl/hrls_count.sv =====
`timescale 1ns / 1ps

module hrls_count import hrls_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  ev_valid,
	input  cls_t  ev,
	output logic  s2_free,
	output logic  stat_valid,
	input  logic  stat_ready,
	output stat_t stat
);

	localparam int EXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
	localparam int MAW = $clog2(N_METHOD);
	localparam int UAW = $clog2(N_URI);

	logic                  s2_v_q;
	cls_t                  cls_s2;
	logic                  out_free;
	logic                  s2_go;
	logic                  ld_s2;
	logic [COUNT_BITS-1:0] m_nxt;
	logic [COUNT_BITS-1:0] u_nxt;
	logic [EXT_W-1:0]      m_ext;
	logic [EXT_W-1:0]      u_ext;

	assign out_free = !stat_valid || stat_ready;
	assign s2_go    = s2_v_q && out_free;
	assign s2_free  = !s2_v_q || out_free;
	assign ld_s2    = ev_valid && s2_free;

	hrls_bank #(
		.DEPTH      (N_METHOD),
		.COUNT_BITS (COUNT_BITS)
	) u_method (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (ld_s2),
		.rd_addr   (MAW'(ev.method_class)),
		.wr_en     (s2_go),
		.nxt_count (m_nxt)
	);

	hrls_bank #(
		.DEPTH      (N_URI),
		.COUNT_BITS (COUNT_BITS)
	) u_uri (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (ld_s2),
		.rd_addr   (UAW'(ev.uri_class)),
		.wr_en     (s2_go),
		.nxt_count (u_nxt)
	);

	assign m_ext = EXT_W'(m_nxt);
	assign u_ext = EXT_W'(u_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (ld_s2) begin
			s2_v_q <= 1'b1;
		end else if (s2_go) begin
			s2_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2)
			cls_s2 <= ev;
	end

	// output register: hold the request until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_valid <= 1'b0;
		end else if (s2_go) begin
			stat_valid <= 1'b1;
		end else if (stat_ready) begin
			stat_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			stat.method_class <= cls_s2.method_class;
			stat.uri_class    <= cls_s2.uri_class;
			stat.method_total <= m_ext[TOTAL_W-1:0];
			stat.uri_total    <= u_ext[TOTAL_W-1:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> (m_nxt != '0 && u_nxt != '0))
		else $error("bumped count is zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q && !s2_go |=> s2_v_q && $stable(cls_s2))
		else $error("stalled count stage lost its line");

endmodule

// ===== rtl/http_request_line_stats_core.sv =====
`timescale 1ns / 1ps
// Request line statistics core.
// Input channel chr (chr_valid/chr_ready): one byte of an HTTP request line per
// request, with line_end set on the last byte of the line. Bytes are taken at
// one per cycle; chr_ready drops only when the count stage and the output
// register are both full and the receiver is stalling.
// Output channel stat (stat_valid/stat_ready): one request per line carrying the
// method and uri classes and the new saturating count of each class (low 32 bits).
// The result passes through the parse register, the counter memory read and the
// counter write-back into the output register. A new line may follow in the very
// next cycle; one result per cycle is sustained while the receiver does not stall,
// as each counter memory entry is read and then written back, with same-entry
// writes forwarded to the following read.
// Reset: arst_n clears the line parser, empties the pipeline and marks every
// counter as zero at once; no clearing pass is needed.
// Receiver stall: the result holds in the output register, the count stage and
// the parse register each hold one more line, then chr_ready goes low.

module http_request_line_stats_core import hrls_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  chr_valid,
	output logic  chr_ready,
	input  chr_t  chr,
	output logic  stat_valid,
	input  logic  stat_ready,
	output stat_t stat
);

	logic ev_valid;
	cls_t ev;
	logic s2_free;

	hrls_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr       (chr),
		.s2_free   (s2_free),
		.ev_valid  (ev_valid),
		.ev        (ev)
	);

	hrls_count #(
		.COUNT_BITS (COUNT_BITS)
	) u_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev_valid   (ev_valid),
		.ev         (ev),
		.s2_free    (s2_free),
		.stat_valid (stat_valid),
		.stat_ready (stat_ready),
		.stat       (stat)
	);

endmodule
